// ===== src/nrth_pkg.sv =====
// nrth_pkg: shared types, widths and the multiply sequence of the ray/triangle hit block
// depends on nothing; used by the interfaces and every module of the block
`default_nettype none

package nrth_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VW            = 32;
  localparam int CW            = VW + 1;
  localparam int DIR_W         = 18;
  localparam int DIST_W        = 33;
  localparam int P_W           = 52;
  localparam int Q_W           = 67;
  localparam int ACC_W         = 104;
  localparam int DET_MAG_W     = 87;
  localparam int TQ_MAG_W      = 102;
  localparam int MUL_STEPS     = 24;
  localparam int STEP_W        = $clog2(MUL_STEPS);
  localparam int BIT_CNT_W     = $clog2(CW + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_ORIGIN_Z     = 3'd2,
    CFG_DIR_X        = 3'd3,
    CFG_DIR_Y        = 3'd4,
    CFG_DIR_Z        = 3'd5,
    CFG_MAX_DISTANCE = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z, A_P0, A_P1, A_P2, A_Q0, A_Q1, A_Q2
  } a_sel_t;

  typedef enum logic [3:0] {
    B_DX, B_DY, B_DZ, B_E1X, B_E1Y, B_E1Z, B_E2X, B_E2Y, B_E2Z, B_TX, B_TY, B_TZ
  } b_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2, D_DET, D_UP, D_VQ, D_TQ
  } dst_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   neg;
    logic   first;
    dst_t   dst;
  } mul_op_t;

  typedef struct packed {
    logic [2:0][VW-1:0]    origin;
    logic [2:0][DIR_W-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic [2:0][CW-1:0] e1;
    logic [2:0][CW-1:0] e2;
    logic [2:0][CW-1:0] tv;
    logic               last;
  } tri_job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MUL, BK_NEG, BK_CHECK, BK_DIV, BK_UPDATE, BK_CMUL, BK_CADD, BK_OUT
  } back_state_t;

  // p = d x e2, q = tv x e1, det = e1.p, up = tv.p, vq = d.q, tq = e2.q
  function automatic mul_op_t mul_step(input logic [STEP_W-1:0] step);
    mul_op_t op;
    op = '{a_sel: A_E1X, b_sel: B_DX, neg: 1'b0, first: 1'b0, dst: D_NONE};
    unique case (step)
      5'd0:  op = '{A_E2Z, B_DY,  1'b0, 1'b1, D_NONE};
      5'd1:  op = '{A_E2Y, B_DZ,  1'b1, 1'b0, D_P0};
      5'd2:  op = '{A_E2X, B_DZ,  1'b0, 1'b1, D_NONE};
      5'd3:  op = '{A_E2Z, B_DX,  1'b1, 1'b0, D_P1};
      5'd4:  op = '{A_E2Y, B_DX,  1'b0, 1'b1, D_NONE};
      5'd5:  op = '{A_E2X, B_DY,  1'b1, 1'b0, D_P2};
      5'd6:  op = '{A_E1Z, B_TY,  1'b0, 1'b1, D_NONE};
      5'd7:  op = '{A_E1Y, B_TZ,  1'b1, 1'b0, D_Q0};
      5'd8:  op = '{A_E1X, B_TZ,  1'b0, 1'b1, D_NONE};
      5'd9:  op = '{A_E1Z, B_TX,  1'b1, 1'b0, D_Q1};
      5'd10: op = '{A_E1Y, B_TX,  1'b0, 1'b1, D_NONE};
      5'd11: op = '{A_E1X, B_TY,  1'b1, 1'b0, D_Q2};
      5'd12: op = '{A_P0,  B_E1X, 1'b0, 1'b1, D_NONE};
      5'd13: op = '{A_P1,  B_E1Y, 1'b0, 1'b0, D_NONE};
      5'd14: op = '{A_P2,  B_E1Z, 1'b0, 1'b0, D_DET};
      5'd15: op = '{A_P0,  B_TX,  1'b0, 1'b1, D_NONE};
      5'd16: op = '{A_P1,  B_TY,  1'b0, 1'b0, D_NONE};
      5'd17: op = '{A_P2,  B_TZ,  1'b0, 1'b0, D_UP};
      5'd18: op = '{A_Q0,  B_DX,  1'b0, 1'b1, D_NONE};
      5'd19: op = '{A_Q1,  B_DY,  1'b0, 1'b0, D_NONE};
      5'd20: op = '{A_Q2,  B_DZ,  1'b0, 1'b0, D_VQ};
      5'd21: op = '{A_Q0,  B_E2X, 1'b0, 1'b1, D_NONE};
      5'd22: op = '{A_Q1,  B_E2Y, 1'b0, 1'b0, D_NONE};
      5'd23: op = '{A_Q2,  B_E2Z, 1'b0, 1'b0, D_TQ};
      default: op = '{A_E1X, B_DX, 1'b0, 1'b0, D_NONE};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== src/nrth_ifs.sv =====
// nrth_tri_if and nrth_res_if: valid/ready channels for triangle and result words
// depends on nrth_pkg
`default_nettype none

interface nrth_tri_if import nrth_pkg::*;;
  logic          valid;
  logic          ready;
  logic [VW-1:0] vert_a_x;
  logic [VW-1:0] vert_a_y;
  logic [VW-1:0] vert_a_z;
  logic [VW-1:0] vert_b_x;
  logic [VW-1:0] vert_b_y;
  logic [VW-1:0] vert_b_z;
  logic [VW-1:0] vert_c_x;
  logic [VW-1:0] vert_c_y;
  logic [VW-1:0] vert_c_z;
  logic          last_triangle;

  modport source (
    output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
           vert_c_x, vert_c_y, vert_c_z, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
           vert_c_x, vert_c_y, vert_c_z, last_triangle,
    output ready
  );
endinterface

interface nrth_res_if import nrth_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] distance;
  logic [VW-1:0]     hit_x;
  logic [VW-1:0]     hit_y;
  logic [VW-1:0]     hit_z;

  modport source (output valid, hit, distance, hit_x, hit_y, hit_z, input ready);
  modport sink (input valid, hit, distance, hit_x, hit_y, hit_z, output ready);
endinterface

`default_nettype wire

// ===== src/nrth_front.sv =====
// nrth_front: accepts triangle words, forms edge and origin offset vectors, queues them
// depends on nrth_pkg and nrth_ifs
`default_nettype none

module nrth_front import nrth_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ray_t       ray,
  nrth_tri_if.sink   triangle,
  output logic       job_valid,
  output tri_job_t   job_word,
  input  logic       job_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tri_job_t           queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;
  tri_job_t           fresh;

  assign triangle.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push      = triangle.valid && triangle.ready;
  assign job_valid = (count != '0);
  assign pop       = job_pop && job_valid;
  assign job_word  = queue[rd_ptr];

  always_comb begin
    fresh.e1[0] = CW'($signed(triangle.vert_b_x)) - CW'($signed(triangle.vert_a_x));
    fresh.e1[1] = CW'($signed(triangle.vert_b_y)) - CW'($signed(triangle.vert_a_y));
    fresh.e1[2] = CW'($signed(triangle.vert_b_z)) - CW'($signed(triangle.vert_a_z));
    fresh.e2[0] = CW'($signed(triangle.vert_c_x)) - CW'($signed(triangle.vert_a_x));
    fresh.e2[1] = CW'($signed(triangle.vert_c_y)) - CW'($signed(triangle.vert_a_y));
    fresh.e2[2] = CW'($signed(triangle.vert_c_z)) - CW'($signed(triangle.vert_a_z));
    fresh.tv[0] = CW'($signed(ray.origin[0])) - CW'($signed(triangle.vert_a_x));
    fresh.tv[1] = CW'($signed(ray.origin[1])) - CW'($signed(triangle.vert_a_y));
    fresh.tv[2] = CW'($signed(ray.origin[2])) - CW'($signed(triangle.vert_a_z));
    fresh.last  = triangle.last_triangle;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/nrth_back.sv =====
// nrth_back: bit-serial multiply sequencer, hit test, serial divider, nearest tracking
// and hit point; depends on nrth_pkg and nrth_ifs
`default_nettype none

module nrth_back import nrth_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ray_t              ray,
  input  logic              max_write,
  input  logic [DIST_W-1:0] max_new,
  input  logic [DIST_W-1:0] max_distance,
  input  logic              job_valid,
  input  tri_job_t          job_word,
  output logic              job_pop,
  nrth_res_if.source        result
);

  localparam int NUM_W   = TQ_MAG_W + FRAC_BITS;
  localparam int DBIG_W  = DET_MAG_W + DIST_W;
  localparam int DIV_W   = (NUM_W > DBIG_W) ? NUM_W : DBIG_W;
  localparam int PROD_W  = DIR_W + DIST_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam logic [ACC_W-1:0] DetEps =
    ((ACC_W'(1) << (3 * FRAC_BITS)) + ACC_W'(500000)) / ACC_W'(1000000);
  localparam logic [DIST_W-1:0] TMin =
    DIST_W'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);

  back_state_t state, state_next;

  tri_job_t               job;
  logic [STEP_W-1:0]      step;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [1:0]             axis;
  logic signed [ACC_W-1:0] acc, a_sh, det, up, vq, tq;
  logic signed [P_W-1:0]  p [3];
  logic signed [Q_W-1:0]  q [3];
  logic [DIV_W-1:0]       rem, dsh;
  logic [DIST_W-1:0]      quo;
  logic                   ok;
  logic [DIST_W-1:0]      nearest;
  logic                   any_hit;
  logic signed [PROD_W-1:0] prod;
  logic [2:0][VW-1:0]     hp;
  logic                   out_v;

  mul_op_t                ms;
  logic signed [ACC_W-1:0] a_src, a_cur, acc_base, term, acc_new;
  logic [CW-1:0]          b_src;
  logic                   b_bit, sub, step_end, last_step, bits_end;
  logic                   out_load;
  logic                   accept;
  logic signed [ACC_W-1:0] d_up, d_upv;
  logic                   ok_next;
  logic [DIV_W-1:0]       num, dbig;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic [VW-1:0]          sat;

  // operand selection for the shared multiplier
  always_comb begin
    ms = mul_step(step);
    unique case (ms.a_sel)
      A_E1X: a_src = ACC_W'($signed(job.e1[0]));
      A_E1Y: a_src = ACC_W'($signed(job.e1[1]));
      A_E1Z: a_src = ACC_W'($signed(job.e1[2]));
      A_E2X: a_src = ACC_W'($signed(job.e2[0]));
      A_E2Y: a_src = ACC_W'($signed(job.e2[1]));
      A_E2Z: a_src = ACC_W'($signed(job.e2[2]));
      A_P0:  a_src = ACC_W'(p[0]);
      A_P1:  a_src = ACC_W'(p[1]);
      A_P2:  a_src = ACC_W'(p[2]);
      A_Q0:  a_src = ACC_W'(q[0]);
      A_Q1:  a_src = ACC_W'(q[1]);
      A_Q2:  a_src = ACC_W'(q[2]);
      default: a_src = '0;
    endcase
    unique case (ms.b_sel)
      B_DX:  b_src = CW'($signed(ray.dir[0]));
      B_DY:  b_src = CW'($signed(ray.dir[1]));
      B_DZ:  b_src = CW'($signed(ray.dir[2]));
      B_E1X: b_src = job.e1[0];
      B_E1Y: b_src = job.e1[1];
      B_E1Z: b_src = job.e1[2];
      B_E2X: b_src = job.e2[0];
      B_E2Y: b_src = job.e2[1];
      B_E2Z: b_src = job.e2[2];
      B_TX:  b_src = job.tv[0];
      B_TY:  b_src = job.tv[1];
      B_TZ:  b_src = job.tv[2];
      default: b_src = '0;
    endcase
    bits_end  = (bit_cnt == BIT_CNT_W'(CW - 1));
    step_end  = bits_end;
    last_step = (step == STEP_W'(MUL_STEPS - 1));
    b_bit     = b_src[bit_cnt[BIT_CNT_W-1:0]];
    a_cur     = (bit_cnt == '0) ? a_src : a_sh;
    acc_base  = ((bit_cnt == '0) && ms.first) ? '0 : acc;
    // top bit of the multiplier word carries negative weight
    sub       = ms.neg ^ bits_end;
    term      = b_bit ? a_cur : '0;
    acc_new   = sub ? acc_base - term : acc_base + term;
  end

  // hit test on sign-corrected terms
  always_comb begin
    d_up    = det - up;
    d_upv   = d_up - vq;
    num     = {{(DIV_W - TQ_MAG_W){1'b0}}, tq[TQ_MAG_W-1:0]} << FRAC_BITS;
    dbig    = {{(DIV_W - DET_MAG_W){1'b0}}, det[DET_MAG_W-1:0]} << DIST_W;
    ok_next = !(det[ACC_W-1:0] < DetEps) && !up[ACC_W-1] && !d_up[ACC_W-1] &&
              !vq[ACC_W-1] && !d_upv[ACC_W-1] && !tq[ACC_W-1] && (tq != '0) &&
              (num < dbig);
    accept  = ok && (quo > TMin) && (quo < nearest);
  end

  // hit point coordinate with saturation
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    sum     = SUM_W'($signed(ray.origin[axis])) + SUM_W'(shifted);
    if (sum[SUM_W-1:VW-1] == '0 || sum[SUM_W-1:VW-1] == '1) begin
      sat = sum[VW-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (job_valid) state_next = BK_MUL;
      BK_MUL:    if (step_end && last_step) state_next = BK_NEG;
      BK_NEG:    state_next = BK_CHECK;
      BK_CHECK:  state_next = ok_next ? BK_DIV : BK_UPDATE;
      BK_DIV:    if (bits_end) state_next = BK_UPDATE;
      BK_UPDATE: state_next = job.last ? BK_CMUL : BK_IDLE;
      BK_CMUL:   state_next = BK_CADD;
      BK_CADD:   state_next = (axis == 2'd2) ? BK_OUT : BK_CMUL;
      BK_OUT:    if (out_load) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state == BK_IDLE) && job_valid;
    out_load = (state == BK_OUT) && (!out_v || result.ready);
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_word;
    end
    unique case (state)
      BK_MUL: begin
        acc  <= acc_new;
        a_sh <= a_cur <<< 1;
        if (step_end) begin
          unique case (ms.dst)
            D_P0:    p[0] <= acc_new[P_W-1:0];
            D_P1:    p[1] <= acc_new[P_W-1:0];
            D_P2:    p[2] <= acc_new[P_W-1:0];
            D_Q0:    q[0] <= acc_new[Q_W-1:0];
            D_Q1:    q[1] <= acc_new[Q_W-1:0];
            D_Q2:    q[2] <= acc_new[Q_W-1:0];
            D_DET:   det  <= acc_new;
            D_UP:    up   <= acc_new;
            D_VQ:    vq   <= acc_new;
            D_TQ:    tq   <= acc_new;
            default: ;
          endcase
        end
      end
      BK_NEG: begin
        if (det[ACC_W-1]) begin
          det <= -det;
          up  <= -up;
          vq  <= -vq;
          tq  <= -tq;
        end
      end
      BK_CHECK: begin
        ok  <= ok_next;
        rem <= num;
        dsh <= dbig >> 1;
        quo <= '0;
      end
      BK_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[DIST_W-2:0], 1'b1};
        end else begin
          quo <= {quo[DIST_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      BK_CMUL: prod <= PROD_W'($signed(ray.dir[axis]) * $signed({1'b0, nearest}));
      BK_CADD: hp[axis] <= sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      bit_cnt <= '0;
      axis    <= '0;
      nearest <= max_distance;
      any_hit <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      if (result.ready && !out_load) begin
        out_v <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (max_write && !any_hit) begin
            nearest <= max_new;
          end
        end
        BK_MUL: begin
          if (step_end) begin
            bit_cnt <= '0;
            step    <= last_step ? '0 : step + 1'b1;
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
          end
        end
        BK_CHECK: bit_cnt <= '0;
        BK_DIV:   bit_cnt <= bits_end ? '0 : bit_cnt + 1'b1;
        BK_UPDATE: begin
          axis <= '0;
          if (accept) begin
            nearest <= quo;
            any_hit <= 1'b1;
          end
        end
        BK_CADD: axis <= axis + 1'b1;
        BK_OUT: begin
          if (out_load) begin
            out_v           <= 1'b1;
            result.hit      <= any_hit;
            result.distance <= any_hit ? nearest : '0;
            result.hit_x    <= any_hit ? hp[0] : '0;
            result.hit_y    <= any_hit ? hp[1] : '0;
            result.hit_z    <= any_hit ? hp[2] : '0;
            nearest         <= max_distance;
            any_hit         <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid = out_v;

endmodule

`default_nettype wire

// ===== src/nearest_ray_triangle_hit_top.sv =====
// nearest_ray_triangle_hit_top: closest-hit ray caster over a triangle stream
// depends on nrth_pkg, nrth_ifs, nrth_front and nrth_back
//
// triangle: one word per triangle (three Q16.16 vertices and last_triangle),
//   taken on valid and ready; a two-word queue sits between intake and compute.
// result: one word (hit, distance, hit point) after each last_triangle word.
// cfg_write/cfg_index/cfg_data set origin, direction and max distance.
// each triangle in the compute engine: 24 products on one bit-serial
//   104-bit multiply-accumulate unit, then a restoring divider for t, plus pop,
//   test and update; a triangle that fails the test before the divide skips the divider.
// a last triangle adds the hit point (one 18x34 multiplier, shared by the
//   three axes) and the result register load.
// while the result word waits on a stalled receiver, the engine goes on until
//   the next result, then holds until the word is taken; the queue keeps
//   taking triangles until full.
// reset (synchronous): origin 0, direction +z, max distance 100000.0,
//   queue empty, no pending result.
`default_nettype none

module nearest_ray_triangle_hit_top import nrth_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  nrth_tri_if.sink             triangle,
  nrth_res_if.source           result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  localparam logic [63:0] DistMask = (64'd1 << DIST_W) - 64'd1;
  localparam logic [63:0] MdFull   = 64'd100000 << FRAC_BITS;
  localparam logic [DIST_W-1:0] MaxDistReset =
    (MdFull > DistMask) ? DIST_W'(DistMask) : DIST_W'(MdFull);
  localparam logic [DIR_W-1:0] DirOne = DIR_W'(64'd1 << FRAC_BITS);

  ray_t              ray;
  logic [DIST_W-1:0] max_distance;
  logic              max_write;
  logic              job_valid;
  logic              job_pop;
  tri_job_t          job_word;

  assign max_write = cfg_write && (cfg_idx_t'(cfg_index) == CFG_MAX_DISTANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ray.origin   <= '0;
      ray.dir[0]   <= '0;
      ray.dir[1]   <= '0;
      ray.dir[2]   <= DirOne;
      max_distance <= MaxDistReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     ray.origin[0] <= cfg_data[VW-1:0];
        CFG_ORIGIN_Y:     ray.origin[1] <= cfg_data[VW-1:0];
        CFG_ORIGIN_Z:     ray.origin[2] <= cfg_data[VW-1:0];
        CFG_DIR_X:        ray.dir[0]    <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:        ray.dir[1]    <= cfg_data[DIR_W-1:0];
        CFG_DIR_Z:        ray.dir[2]    <= cfg_data[DIR_W-1:0];
        CFG_MAX_DISTANCE: max_distance  <= cfg_data;
        default: ;
      endcase
    end
  end

  nrth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ray       (ray),
    .triangle  (triangle),
    .job_valid (job_valid),
    .job_word  (job_word),
    .job_pop   (job_pop)
  );

  nrth_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ray          (ray),
    .max_write    (max_write),
    .max_new      (cfg_data),
    .max_distance (max_distance),
    .job_valid    (job_valid),
    .job_word     (job_word),
    .job_pop      (job_pop),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== tb/tb_nearest_ray_triangle_hit_top.sv =====
// tb_nearest_ray_triangle_hit_top: self-checking bench for the nearest ray/triangle hit block
// depends on nrth_pkg, nrth_ifs and nearest_ray_triangle_hit_top; predicts each sweep
// result in 128-bit integer math and checks every result word in order
`default_nettype none

module tb_nearest_ray_triangle_hit_top;
  import nrth_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam logic [127:0] DET_EPS = ((128'd1 << (3 * FB)) + 128'd500000) / 128'd1000000;
  localparam logic [32:0] T_MIN = 33'(((2 << FB) + 50) / 100);
  localparam logic [32:0] DIST_MAX = 33'h1_FFFF_FFFF;
  localparam logic [32:0] DIST_DEF = 33'd6553600000;
  localparam int ONE = 1 << FB;

  typedef struct {
    logic signed [31:0] v[9];
    logic               last;
  } tri_word_t;

  typedef struct {
    logic        hit;
    logic [32:0] distance;
    logic [31:0] hx, hy, hz;
  } hit_word_t;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0] cfg_data;

  nrth_tri_if tri_ch();
  nrth_res_if res_ch();

  nearest_ray_triangle_hit_top uut (
    .clk(clk), .rst(rst), .triangle(tri_ch), .result(res_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ray and sweep state of the predictor
  logic signed [31:0] ray_org[3];
  logic signed [17:0] ray_dir[3];
  logic [32:0] bound_dist;
  logic [32:0] near_dist;
  logic        near_hit;

  tri_word_t pending_tris[$];
  hit_word_t expected_hits[$];
  int mismatches = 0;
  int results_seen = 0;
  int tris_taken = 0;
  logic tri_took = 0;
  int hold_left = 0;
  logic held_once = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [127:0] dot3(input logic signed [127:0] x[3],
                                                input logic signed [127:0] y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic logic [31:0] hit_axis(input int ax, input logic [32:0] t);
    logic signed [63:0] dd, tt, s;
    dd = ray_dir[ax];
    tt = {31'd0, t};
    s = 64'(ray_org[ax]) + ((dd * tt) >>> FB);
    if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic void advance_sweep(input tri_word_t w);
    logic signed [127:0] a[3], e1[3], e2[3], tv[3], d[3], p[3], q[3];
    logic signed [127:0] det, up, vq, tq;
    logic [127:0] quo;
    hit_word_t r;
    logic ok;
    for (int i = 0; i < 3; i++) begin
      a[i] = w.v[i];
      e1[i] = 128'(w.v[3 + i]) - a[i];
      e2[i] = 128'(w.v[6 + i]) - a[i];
      tv[i] = 128'(ray_org[i]) - a[i];
      d[i] = ray_dir[i];
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = tv[1] * e1[2] - tv[2] * e1[1];
    q[1] = tv[2] * e1[0] - tv[0] * e1[2];
    q[2] = tv[0] * e1[1] - tv[1] * e1[0];
    det = dot3(e1, p);
    up = dot3(tv, p);
    vq = dot3(d, q);
    tq = dot3(e2, q);
    if (det < 0) begin
      det = -det; up = -up; vq = -vq; tq = -tq;
    end
    ok = 1;
    if (det < $signed(DET_EPS)) ok = 0;
    if (up < 0 || up > det || vq < 0 || up + vq > det || tq <= 0) ok = 0;
    if (ok) begin
      quo = $unsigned(tq <<< FB) / $unsigned(det);
      if (quo > 128'(DIST_MAX) || quo[32:0] <= T_MIN) ok = 0;
      else if (quo[32:0] < near_dist) begin
        near_dist = quo[32:0];
        near_hit = 1;
      end
    end
    if (w.last) begin
      r = '{hit: 1'b0, distance: 33'd0, hx: 32'd0, hy: 32'd0, hz: 32'd0};
      if (near_hit) begin
        r.hit = 1;
        r.distance = near_dist;
        r.hx = hit_axis(0, near_dist);
        r.hy = hit_axis(1, near_dist);
        r.hz = hit_axis(2, near_dist);
      end
      expected_hits.push_back(r);
      near_dist = bound_dist;
      near_hit = 0;
    end
  endfunction

  // triangle side: acceptance at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    tri_took <= !rst && tri_ch.valid && tri_ch.ready;
    if (!rst && tri_ch.valid && tri_ch.ready) begin
      advance_sweep(pending_tris[0]);
      void'(pending_tris.pop_front());
      tris_taken <= tris_taken + 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && !(tri_ch.valid && !tri_took)) begin
      if (pending_tris.size() > 0 &&
          ((tris_taken > 250 && tris_taken < 420) || $urandom_range(0, 99) >= 35)) begin
        tri_ch.valid <= 1;
        tri_ch.vert_a_x <= pending_tris[0].v[0];
        tri_ch.vert_a_y <= pending_tris[0].v[1];
        tri_ch.vert_a_z <= pending_tris[0].v[2];
        tri_ch.vert_b_x <= pending_tris[0].v[3];
        tri_ch.vert_b_y <= pending_tris[0].v[4];
        tri_ch.vert_b_z <= pending_tris[0].v[5];
        tri_ch.vert_c_x <= pending_tris[0].v[6];
        tri_ch.vert_c_y <= pending_tris[0].v[7];
        tri_ch.vert_c_z <= pending_tris[0].v[8];
        tri_ch.last_triangle <= pending_tris[0].last;
      end else begin
        tri_ch.valid <= 0;
      end
    end
  end

  // result side: long hold-off once, a calm stretch, random stalls otherwise
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        res_ch.ready <= 0;
        hold_left <= hold_left - 1;
      end else if (results_seen == 25 && !held_once) begin
        res_ch.ready <= 0;
        held_once <= 1;
        hold_left <= 4000;
      end else if (results_seen > 60 && results_seen < 110) begin
        res_ch.ready <= 1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result word: expected none, got hit %0b distance %0d",
                 $time, res_ch.hit, res_ch.distance);
        mismatches++;
      end else begin
        if (res_ch.hit !== expected_hits[0].hit || res_ch.distance !== expected_hits[0].distance
            || res_ch.hit_x !== expected_hits[0].hx || res_ch.hit_y !== expected_hits[0].hy
            || res_ch.hit_z !== expected_hits[0].hz) begin
          $display("%0t mismatch: expected hit %0b dist %h pt %h %h %h, got %0b %h %h %h %h",
                   $time, expected_hits[0].hit, expected_hits[0].distance, expected_hits[0].hx,
                   expected_hits[0].hy, expected_hits[0].hz, res_ch.hit, res_ch.distance,
                   res_ch.hit_x, res_ch.hit_y, res_ch.hit_z);
          mismatches++;
        end
        void'(expected_hits.pop_front());
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [32:0] val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= CFG_ORIGIN_Z) ray_org[idx] = val[31:0];
    else if (idx <= CFG_DIR_Z) ray_dir[idx - CFG_DIR_X] = val[17:0];
    else begin
      bound_dist = val;
      if (!near_hit) near_dist = val;
    end
    @(negedge clk);
    cfg_write <= 0;
  endtask

  function automatic tri_word_t flat_tri(input int z, input int cx, input int cy, input int h,
                                         input logic flip, input logic last);
    tri_word_t w;
    w.v = '{cx - h, cy - h, z, cx + h, cy - h, z, cx, cy + h, z};
    if (flip) begin
      w.v[3] = cx; w.v[4] = cy + h; w.v[6] = cx + h; w.v[7] = cy - h;
    end
    w.last = last;
    return w;
  endfunction

  function automatic tri_word_t aimed_tri(input logic [32:0] t, input int spread,
                                          input logic last);
    tri_word_t w;
    logic signed [63:0] dd, tt, pt;
    for (int i = 0; i < 3; i++) begin
      dd = ray_dir[i];
      tt = {31'd0, t};
      pt = 64'(ray_org[i]) + ((dd * tt) >>> FB);
      for (int k = 0; k < 3; k++)
        w.v[3 * k + i] = 32'(pt + $urandom_range(0, 2 * spread) - spread);
    end
    w.last = last;
    return w;
  endfunction

  function automatic tri_word_t noise_tri(input logic last);
    tri_word_t w;
    for (int i = 0; i < 9; i++) w.v[i] = $urandom;
    w.last = last;
    return w;
  endfunction

  task automatic drain;
    wait (pending_tris.size() == 0 && expected_hits.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [32:0] md;
    int n, sweep_len, pick;
    logic lst;
    rst = 1;
    cfg_write = 0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data = 0;
    tri_ch.valid = 0;
    tri_ch.vert_a_x = 0; tri_ch.vert_a_y = 0; tri_ch.vert_a_z = 0;
    tri_ch.vert_b_x = 0; tri_ch.vert_b_y = 0; tri_ch.vert_b_z = 0;
    tri_ch.vert_c_x = 0; tri_ch.vert_c_y = 0; tri_ch.vert_c_z = 0;
    tri_ch.last_triangle = 0;
    res_ch.ready = 0;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 18'(ONE)};
    bound_dist = DIST_DEF;
    near_dist = DIST_DEF;
    near_hit = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed sweeps on the reset ray
    pending_tris.push_back(flat_tri(10 * ONE, 0, 0, ONE, 0, 0));
    pending_tris.push_back(flat_tri(5 * ONE, 0, 0, ONE, 1, 0));
    pending_tris.push_back(flat_tri(7 * ONE, 0, 0, ONE, 0, 1));
    pending_tris.push_back(flat_tri(0, 0, 0, 0, 0, 1));
    pending_tris.push_back(flat_tri(-5 * ONE, 0, 0, ONE, 0, 1));
    pending_tris.push_back(flat_tri(655, 0, 0, ONE, 0, 1));
    pending_tris.push_back(flat_tri(int'(T_MIN), 0, 0, ONE, 0, 0));
    pending_tris.push_back(flat_tri(int'(T_MIN) + 1, 0, 0, ONE, 1, 1));
    pending_tris.push_back(flat_tri(3 * ONE, 10 * ONE, 0, ONE, 0, 1));
    pending_tris.push_back(flat_tri(3 * ONE, 0, 0, ONE, 0, 1) );
    pending_tris.push_back(flat_tri(32'h7FFF_FFFF, 0, 0, 32'h3FFF_FFFF, 0, 1));
    pending_tris.push_back(flat_tri(32'h8000_0000, 0, 0, 32'h3FFF_FFFF, 1, 1));
    begin
      tri_word_t w;
      w.last = 1;
      w.v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      pending_tris.push_back(w);
      w.v = '{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 0};
      pending_tris.push_back(w);
    end
    drain();
    // hit exactly at the bound is not closer
    write_reg(CFG_MAX_DISTANCE, 33'(20 * ONE));
    pending_tris.push_back(flat_tri(20 * ONE, 0, 0, ONE, 0, 1));
    pending_tris.push_back(flat_tri(20 * ONE - 1, 0, 0, ONE, 0, 1));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] o;
        logic [17:0] dv;
        case (ph)
          1: o = 32'h7FFF_FFFF;
          2: o = 32'h8000_0000;
          3: o = 32'h7FFF_0000;
          default: o = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
        case (ph)
          1: dv = (i == 0) ? -18'sd65536 : 18'd0;
          2: dv = (i == 1) ? 18'd65536 : 18'd0;
          3: dv = (i == 0) ? 18'd65536 : 18'd0;
          4: dv = (i == 0) ? 18'h1FFFF : (i == 1) ? 18'h20000 : 18'd0;
          default: dv = 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
        write_reg(cfg_idx_t'(CFG_ORIGIN_X + i), {1'b0, o});
        write_reg(cfg_idx_t'(CFG_DIR_X + i), {15'd0, dv});
      end
      case (ph)
        5: md = 33'd0;
        6: md = DIST_DEF;
        7: md = DIST_MAX;
        8: md = 33'($urandom_range(1 << 16, 1 << 21));
        default: md = {1'b0, $urandom} % DIST_DEF;
      endcase
      write_reg(CFG_MAX_DISTANCE, md);
      n = 0;
      while (n < 92) begin
        sweep_len = $urandom_range(1, 8);
        for (int k = 0; k < sweep_len; k++) begin
          lst = (k == sweep_len - 1);
          pick = $urandom_range(0, 99);
          if (pick < 70)
            pending_tris.push_back(aimed_tri(33'($urandom_range(1, 1 << 22)),
                                             1 << $urandom_range(10, 19), lst));
          else if (pick < 85)
            pending_tris.push_back(aimed_tri(33'($urandom_range(1000, 1600)),
                                             1 << $urandom_range(8, 14), lst));
          else
            pending_tris.push_back(noise_tri(lst));
        end
        n += sweep_len;
      end
      drain();
    end

    wait (pending_tris.size() == 0 && expected_hits.size() == 0);
    repeat (2000) @(negedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/nrth_pkg.sv
src/nrth_ifs.sv
src/nrth_front.sv
src/nrth_back.sv
src/nearest_ray_triangle_hit_top.sv
tb/tb_nearest_ray_triangle_hit_top.sv
